### sv/cmf_pkg.sv
// Shared types and constants for the click-motion freeze filter.
package cmf_pkg;

   localparam int TS_W      = 48;
   localparam int DELTA_W   = 16;
   localparam int WAIT_W    = 32;
   localparam int THR_W     = 16;
   localparam int SCALE_W   = 16;
   localparam int LIN_W     = THR_W + SCALE_W;
   localparam int LIMIT_W   = 2 * LIN_W - 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DW    = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_TIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE     = 2'd2;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

   typedef enum logic [1:0] {
      OP_PRESS   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_MOTION  = 2'd2,
      OP_OTHER   = 2'd3
   } op_type;

   typedef struct packed {
      op_type                    operation;
      logic [TS_W-1:0]           event_time;
      logic signed [DELTA_W-1:0] delta_x;
      logic signed [DELTA_W-1:0] delta_y;
   } item_type;

   typedef struct packed {
      logic [WAIT_W-1:0]  wait_time_usec;
      logic [LIMIT_W-1:0] limit_shifted;
   } cfg_type;

endpackage

### sv/cmf_req_if.sv
// Event channel: valid/ready handshake with one pointer event per transfer.
interface cmf_req_if;
   logic                              valid;
   logic                              ready;
   cmf_pkg::op_type                   operation;
   logic [cmf_pkg::TS_W-1:0]          event_time;
   logic signed [cmf_pkg::DELTA_W-1:0] delta_x;
   logic signed [cmf_pkg::DELTA_W-1:0] delta_y;

   modport source (output valid, operation, event_time, delta_x, delta_y, input ready);
   modport sink   (input valid, operation, event_time, delta_x, delta_y, output ready);
endinterface

### sv/cmf_rsp_if.sv
// Decision channel: valid/ready handshake with one pass/drop flag per transfer.
interface cmf_rsp_if;
   logic valid;
   logic ready;
   logic pass_event;

   modport source (output valid, pass_event, input ready);
   modport sink   (input valid, pass_event, output ready);
endinterface

### sv/cmf_csr.sv
// Configuration registers and the squared distance limit.
module cmf_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [cmf_pkg::CSR_IDX_W-1:0]   index,
   input  logic [cmf_pkg::CSR_DW-1:0]      wdata,
   output cmf_pkg::cfg_type                cfg
);

   logic [cmf_pkg::WAIT_W-1:0]    wait_ff;
   logic [cmf_pkg::THR_W-1:0]     thr_ff;
   logic [cmf_pkg::SCALE_W-1:0]   scale_ff;
   logic [cmf_pkg::LIN_W-1:0]     lin_ff, lin_in;
   logic [cmf_pkg::LIMIT_W-1:0]   limit_ff, limit_in;
   logic [2*cmf_pkg::LIN_W-1:0]   lin_sq;
   logic [cmf_pkg::THR_W-1:0]     wdata16;

   assign wdata16 = wdata[cmf_pkg::THR_W-1:0];

   always_comb begin
      lin_in = lin_ff;
      if (wr_en && index == cmf_pkg::CSR_THRESHOLD) begin
         lin_in = wdata16 * scale_ff;
      end else if (wr_en && index == cmf_pkg::CSR_SCALE) begin
         lin_in = thr_ff * wdata16;
      end
   end

   // limit is registered from lin in the following cycle; only bits 16 and up of lin squared are compared
   assign lin_sq   = lin_ff * lin_ff;
   assign limit_in = lin_sq[2*cmf_pkg::LIN_W-1:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ff  <= '0;
         thr_ff   <= '0;
         scale_ff <= cmf_pkg::SCALE_RESET;
         lin_ff   <= '0;
         limit_ff <= '0;
      end else begin
         if (wr_en && index == cmf_pkg::CSR_WAIT_TIME) begin
            wait_ff <= wdata[cmf_pkg::WAIT_W-1:0];
         end
         if (wr_en && index == cmf_pkg::CSR_THRESHOLD) begin
            thr_ff <= wdata16;
         end
         if (wr_en && index == cmf_pkg::CSR_SCALE) begin
            scale_ff <= wdata16;
         end
         lin_ff   <= lin_in;
         limit_ff <= limit_in;
      end
   end

   assign cfg.wait_time_usec = wait_ff;
   assign cfg.limit_shifted  = limit_ff;

endmodule

### sv/cmf_core.sv
// Filter state and the pass/drop decision for one event.
module cmf_core #(
   parameter int ACCUM_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  cmf_pkg::item_type  item,
   input  cmf_pkg::cfg_type   cfg,
   output logic               pass_event
);

   localparam int DW = 2 * ACCUM_BITS + 1;
   localparam int CW = (DW > cmf_pkg::LIMIT_W) ? DW : cmf_pkg::LIMIT_W;

   logic [cmf_pkg::TS_W-1:0]    freeze_ff, freeze_in;
   logic                        first_ff, first_in;
   logic                        second_ff, second_in;
   logic                        frozen_ff, frozen_in;
   logic [ACCUM_BITS-1:0]       accum_x_ff, accum_x_in;
   logic [ACCUM_BITS-1:0]       accum_y_ff, accum_y_in;

   logic [ACCUM_BITS-1:0]       sum_x, sum_y, mag_x, mag_y;
   logic [2*ACCUM_BITS-1:0]     sq_x, sq_y;
   logic [DW-1:0]               dist_sq;
   logic                        far;
   logic [cmf_pkg::TS_W-1:0]    elapsed;
   logic                        over, under;

   function automatic logic [ACCUM_BITS-1:0] sat_add(
      input logic [ACCUM_BITS-1:0]       acc,
      input logic [cmf_pkg::DELTA_W-1:0] d
   );
      logic [ACCUM_BITS:0] s;
      s = {acc[ACCUM_BITS-1], acc}
        + {{(ACCUM_BITS+1-cmf_pkg::DELTA_W){d[cmf_pkg::DELTA_W-1]}}, d};
      if (s[ACCUM_BITS] != s[ACCUM_BITS-1]) begin
         return s[ACCUM_BITS] ? {1'b1, {(ACCUM_BITS-1){1'b0}}}
                              : {1'b0, {(ACCUM_BITS-1){1'b1}}};
      end
      return s[ACCUM_BITS-1:0];
   endfunction

   assign sum_x   = sat_add(accum_x_ff, item.delta_x);
   assign sum_y   = sat_add(accum_y_ff, item.delta_y);
   assign mag_x   = sum_x[ACCUM_BITS-1] ? (~sum_x + 1'b1) : sum_x;
   assign mag_y   = sum_y[ACCUM_BITS-1] ? (~sum_y + 1'b1) : sum_y;
   assign sq_x    = mag_x * mag_x;
   assign sq_y    = mag_y * mag_y;
   assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
   assign far     = CW'(dist_sq) > CW'(cfg.limit_shifted);

   // elapsed time is signed; negative counts as inside the window
   assign elapsed = item.event_time - freeze_ff;
   assign over    = !elapsed[cmf_pkg::TS_W-1]
                    && (elapsed > cmf_pkg::TS_W'(cfg.wait_time_usec));
   assign under   = elapsed[cmf_pkg::TS_W-1]
                    || (elapsed < cmf_pkg::TS_W'(cfg.wait_time_usec));

   always_comb begin
      freeze_in  = freeze_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      frozen_in  = frozen_ff;
      accum_x_in = accum_x_ff;
      accum_y_in = accum_y_ff;
      pass_event = 1'b1;
      case (item.operation)
         cmf_pkg::OP_PRESS: begin
            if (!first_ff) begin
               frozen_in = 1'b1;
               first_in  = 1'b1;
               freeze_in = item.event_time;
            end else begin
               second_in = 1'b1;
            end
         end
         cmf_pkg::OP_RELEASE: begin
            if (over || second_ff) begin
               freeze_in  = '0;
               first_in   = 1'b0;
               second_in  = 1'b0;
               frozen_in  = 1'b0;
               accum_x_in = '0;
               accum_y_in = '0;
            end
         end
         cmf_pkg::OP_MOTION: begin
            if (frozen_ff) begin
               if (far || !under) begin
                  freeze_in  = '0;
                  first_in   = 1'b0;
                  second_in  = 1'b0;
                  frozen_in  = 1'b0;
                  accum_x_in = '0;
                  accum_y_in = '0;
               end else begin
                  accum_x_in = sum_x;
                  accum_y_in = sum_y;
                  pass_event = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freeze_ff  <= '0;
         first_ff   <= 1'b0;
         second_ff  <= 1'b0;
         frozen_ff  <= 1'b0;
         accum_x_ff <= '0;
         accum_y_ff <= '0;
      end else if (fire) begin
         freeze_ff  <= freeze_in;
         first_ff   <= first_in;
         second_ff  <= second_in;
         frozen_ff  <= frozen_in;
         accum_x_ff <= accum_x_in;
         accum_y_ff <= accum_y_in;
      end
   end

endmodule

### sv/click_motion_freeze_filter.sv
// Click-motion freeze filter top level. Each pointer event gets one pass/drop
// flag. Events are taken one per cycle with no gaps while the result side keeps
// up; the event sits in the input register and its flag is loaded into the
// decision register when the decision stage fires, which needs the result
// register free or being drained. The decision path is the saturating
// accumulate, two squares, an add and a compare. A threshold or scale write
// reaches the squared distance limit through the lin and limit registers.
module click_motion_freeze_filter #(
   parameter int ACCUM_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   cmf_req_if.sink                       req,
   cmf_rsp_if.source                     rsp,
   input  logic                          csr_wr_en,
   input  logic [cmf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cmf_pkg::CSR_DW-1:0]    csr_wdata
);

   cmf_pkg::item_type item_ff;
   cmf_pkg::cfg_type  cfg;
   logic              item_valid_ff;
   logic              rsp_valid_ff;
   logic              rsp_pass_ff;
   logic              fire;
   logic              pass_in;

   // decision stage moves when the result register is free or being drained
   assign fire      = item_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !item_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req.ready) begin
         item_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff.operation  <= req.operation;
         item_ff.event_time <= req.event_time;
         item_ff.delta_x    <= req.delta_x;
         item_ff.delta_y    <= req.delta_y;
      end
   end

   cmf_csr u_csr (
      .clock (clock),
      .reset (reset),
      .wr_en (csr_wr_en),
      .index (csr_index),
      .wdata (csr_wdata),
      .cfg   (cfg)
   );

   cmf_core #(
      .ACCUM_BITS (ACCUM_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (item_ff),
      .cfg        (cfg),
      .pass_event (pass_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_pass_ff <= pass_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.pass_event = rsp_pass_ff;

endmodule

### tb/tb_top.sv
// Testbench for the click-motion freeze filter: directed and random events against a model.
module tb_top;
   import cmf_pkg::*;

   localparam int ACC_W = 24;
   localparam longint ACC_MAX = (longint'(1) << (ACC_W - 1)) - 1;
   localparam longint ACC_MIN = -ACC_MAX - 1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic signed [DELTA_W-1:0] DELTA_MAX = 16'sh7FFF;
   localparam logic signed [DELTA_W-1:0] DELTA_MIN = 16'sh8000;
   localparam int HOLD_CYCLES = 60;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DW-1:0] csr_wdata;

   cmf_req_if req_if();
   cmf_rsp_if rsp_if();

   click_motion_freeze_filter DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // decision model state
   logic [TS_W-1:0] hold_start;
   logic press_one, press_two, frozen;
   longint acc_x, acc_y;
   logic [63:0] limit_sq;
   logic [WAIT_W-1:0] wait_us;
   logic [THR_W-1:0] thr_px;
   logic [SCALE_W-1:0] scale_q8;

   // stimulus side
   item_type event_queue[$];
   logic pass_expected[$];
   int events_queued = 0;
   int events_taken = 0;
   int error_count = 0;
   int cycles = 0;
   int send_idle_pct = 9;
   int recv_stall_pct = 83;
   int hold_count = 0;
   int hold_seen = 0;
   int hold_left = 0;
   logic req_taken = 1'b0;
   logic [TS_W-1:0] stim_t = '0;
   logic [WAIT_W-1:0] stim_wait = '0;
   logic [THR_W-1:0] stim_thr = '0;
   logic [SCALE_W-1:0] stim_scale = SCALE_RESET;
   item_type cur;

   function automatic void unfreeze();
      hold_start = '0;
      press_one = 1'b0;
      press_two = 1'b0;
      frozen = 1'b0;
      acc_x = 0;
      acc_y = 0;
   endfunction

   function automatic longint sat_add(longint acc, logic signed [DELTA_W-1:0] d);
      longint s;
      s = acc + longint'(d);
      if (s > ACC_MAX) return ACC_MAX;
      if (s < ACC_MIN) return ACC_MIN;
      return s;
   endfunction

   function automatic logic [63:0] square(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      return 64'(m * m);
   endfunction

   function automatic logic filter_decide(item_type it);
      logic [TS_W-1:0] dt;
      logic over, under, far;
      logic [63:0] dist_sq;
      logic pass;
      pass = 1'b1;
      dt = it.event_time - hold_start;
      over = !dt[TS_W-1] && (dt > 48'(wait_us));
      under = dt[TS_W-1] || (dt < 48'(wait_us));
      case (it.operation)
         OP_PRESS: begin
            if (!press_one) begin
               frozen = 1'b1;
               press_one = 1'b1;
               hold_start = it.event_time;
            end else begin
               press_two = 1'b1;
            end
         end
         OP_RELEASE: begin
            if (over || press_two) unfreeze();
         end
         OP_MOTION: begin
            if (frozen) begin
               acc_x = sat_add(acc_x, it.delta_x);
               acc_y = sat_add(acc_y, it.delta_y);
               dist_sq = square(acc_x) + square(acc_y);
               far = dist_sq > (limit_sq >> 16);
               if (far || !under) unfreeze();
               else pass = 1'b0;
            end
         end
         default: ;
      endcase
      return pass;
   endfunction

   // scoreboard, prediction, config tracking, timeout
   always @(posedge clock) begin
      logic exp_pass;
      logic [31:0] lin;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (reset) begin
            unfreeze();
            wait_us = '0;
            thr_px = '0;
            scale_q8 = SCALE_RESET;
            limit_sq = '0;
         end else begin
            if (csr_wr_en) begin
               case (csr_index)
                  CSR_WAIT_TIME: wait_us = csr_wdata[WAIT_W-1:0];
                  CSR_THRESHOLD: thr_px = csr_wdata[THR_W-1:0];
                  CSR_SCALE:     scale_q8 = csr_wdata[SCALE_W-1:0];
                  default: ;
               endcase
               lin = thr_px * scale_q8;
               limit_sq = 64'(lin) * 64'(lin);
            end
            if (rsp_if.valid && rsp_if.ready) begin
               if (pass_expected.size() == 0) begin
                  $error("pass_event transfer with none expected: expected none, actual %0b",
                         rsp_if.pass_event);
                  error_count++;
               end else begin
                  exp_pass = pass_expected.pop_front();
                  if (rsp_if.pass_event !== exp_pass) begin
                     $error("pass_event mismatch: expected %0b, actual %0b",
                            exp_pass, rsp_if.pass_event);
                     error_count++;
                  end
               end
            end
            if (req_if.valid && req_if.ready) begin
               cur.operation = req_if.operation;
               cur.event_time = req_if.event_time;
               cur.delta_x = req_if.delta_x;
               cur.delta_y = req_if.delta_y;
               pass_expected.push_back(filter_decide(cur));
               events_taken++;
            end
         end
      end
   end

   // event driver
   always @(negedge clock) begin
      item_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.operation <= OP_OTHER;
         req_if.event_time <= '0;
         req_if.delta_x <= '0;
         req_if.delta_y <= '0;
      end else if (!req_if.valid || req_taken) begin
         if (event_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = event_queue.pop_front();
            req_if.valid <= 1'b1;
            req_if.operation <= nxt.operation;
            req_if.event_time <= nxt.event_time;
            req_if.delta_x <= nxt.delta_x;
            req_if.delta_y <= nxt.delta_y;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // decision receiver
   always @(negedge clock) begin
      if (hold_seen != hold_count) begin
         hold_seen = hold_count;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic signed [DELTA_W-1:0] rand_delta();
      logic [31:0] r;
      r = $urandom();
      return r[DELTA_W-1:0];
   endfunction

   function automatic logic signed [DELTA_W-1:0] near_delta(int mag);
      int v;
      v = int'($urandom_range(0, 2 * mag)) - mag;
      return 16'(v);
   endfunction

   task automatic add_event(op_type op, logic [TS_W-1:0] ts,
                            logic signed [DELTA_W-1:0] dx, logic signed [DELTA_W-1:0] dy);
      item_type it;
      it.operation = op;
      it.event_time = ts;
      it.delta_x = dx;
      it.delta_y = dy;
      event_queue.push_back(it);
      events_queued++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DW-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_WAIT_TIME: stim_wait = val[WAIT_W-1:0];
         CSR_THRESHOLD: stim_thr = val[THR_W-1:0];
         CSR_SCALE:     stim_scale = val[SCALE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(logic [31:0] w, logic [31:0] t, logic [31:0] s);
      write_reg(CSR_WAIT_TIME, w);
      write_reg(CSR_THRESHOLD, t);
      write_reg(CSR_SCALE, s);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (events_taken != events_queued || pass_expected.size() != 0);
   endtask

   task automatic gesture();
      int span, mag;
      longint lin;
      span = (stim_wait == 0) ? 3 : int'(stim_wait / 3) + 1;
      lin = (longint'(stim_thr) * longint'(stim_scale)) >> 8;
      mag = (lin / 3 + 2 > 32767) ? 32767 : int'(lin / 3 + 2);
      stim_t += $urandom_range(0, span);
      add_event(OP_PRESS, stim_t, rand_delta(), rand_delta());
      if ($urandom_range(3) == 0) begin
         stim_t += $urandom_range(0, span);
         add_event(OP_PRESS, stim_t, rand_delta(), rand_delta());
      end
      repeat ($urandom_range(1, 8)) begin
         stim_t += $urandom_range(0, span);
         if ($urandom_range(9) == 0)
            add_event(OP_MOTION, stim_t, rand_delta(), rand_delta());
         else
            add_event(OP_MOTION, stim_t, near_delta(mag), near_delta(mag));
      end
      if ($urandom_range(4) == 0) stim_t -= $urandom_range(0, span);
      else stim_t += $urandom_range(0, span);
      add_event(OP_RELEASE, stim_t, rand_delta(), rand_delta());
   endtask

   task automatic noise();
      logic [63:0] r;
      op_type op;
      op = op_type'($urandom_range(3));
      r = {$urandom(), $urandom()};
      if ($urandom_range(1) == 0) r = 64'(stim_t) + $urandom_range(0, 5000);
      add_event(op, r[TS_W-1:0], rand_delta(), rand_delta());
   endtask

   task automatic random_part(int n);
      int target;
      target = events_queued + n;
      while (events_queued < target) begin
         if ($urandom_range(3) != 0) gesture();
         else repeat ($urandom_range(1, 3)) noise();
      end
   endtask

   // accumulators pinned at both rails under an unreachable distance limit
   task automatic saturation_run();
      stim_t += 5;
      add_event(OP_PRESS, stim_t, DELTA_MIN, DELTA_MAX);
      repeat (270) begin
         stim_t += $urandom_range(1, 50);
         add_event(OP_MOTION, stim_t, DELTA_MAX, DELTA_MIN);
      end
      repeat (10) begin
         stim_t += 1;
         add_event(OP_MOTION, stim_t, DELTA_MIN, DELTA_MAX);
      end
      add_event(OP_RELEASE, stim_t + 1, 16'sd0, 16'sd0);
      add_event(OP_PRESS, stim_t + 2, 16'sd0, 16'sd0);
      add_event(OP_RELEASE, stim_t + 3, 16'sd0, 16'sd0);
      stim_t += 3;
   endtask

   initial begin
      csr_wr_en = 1'b0;
      csr_index = CSR_WAIT_TIME;
      csr_wdata = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: wait 1000 us, limit 10 px
      set_config(1000, 10, 256);
      @(posedge clock);
      add_event(OP_RELEASE, 48'd5, 16'sd0, 16'sd0);
      add_event(OP_OTHER, 48'd6, DELTA_MAX, DELTA_MIN);
      add_event(OP_MOTION, 48'd7, 16'sd100, 16'sd100);
      add_event(OP_PRESS, 48'd1000, 16'sd0, 16'sd0);
      add_event(OP_MOTION, 48'd1010, 16'sd3, 16'sd4);
      add_event(OP_MOTION, 48'd1020, DELTA_MIN, DELTA_MAX);
      add_event(OP_PRESS, 48'd2000, 16'sd0, 16'sd0);
      add_event(OP_PRESS, 48'd2100, 16'sd0, 16'sd0);
      add_event(OP_MOTION, 48'd2200, 16'sd1, -16'sd1);
      add_event(OP_RELEASE, 48'd2300, 16'sd0, 16'sd0);
      add_event(OP_PRESS, 48'd3000, 16'sd0, 16'sd0);
      add_event(OP_RELEASE, 48'd3500, 16'sd0, 16'sd0);
      add_event(OP_MOTION, 48'd3999, 16'sd0, 16'sd0);
      add_event(OP_MOTION, 48'd4000, 16'sd0, 16'sd0);
      add_event(OP_PRESS, 48'd5000, 16'sd0, 16'sd0);
      add_event(OP_RELEASE, 48'd6001, 16'sd0, 16'sd0);
      add_event(OP_PRESS, 48'd7000, 16'sd0, 16'sd0);
      add_event(OP_MOTION, 48'd6000, 16'sd0, 16'sd0);
      add_event(OP_RELEASE, 48'd6500, 16'sd0, 16'sd0);
      add_event(OP_MOTION, 48'hFFFF_FFFF_FFFF, DELTA_MAX, DELTA_MAX);
      add_event(OP_OTHER, 48'hFFFF_FFFF_FFFF, DELTA_MIN, DELTA_MIN);
      add_event(OP_RELEASE, 48'd8001, 16'sd0, 16'sd0);
      stim_t = 48'd10000;
      wait_drained();

      set_config(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
      @(posedge clock);
      saturation_run();
      random_part(40);
      wait_drained();

      set_config(0, 0, 0);
      write_reg(CSR_UNUSED, $urandom());
      @(posedge clock);
      send_idle_pct = 83;
      recv_stall_pct = 9;
      random_part(65);
      wait_drained();

      set_config($urandom_range(50, 5000), $urandom_range(1, 300), $urandom_range(64, 1024));
      @(posedge clock);
      random_part(65);
      wait_drained();

      set_config($urandom(), $urandom_range(1, 2000), $urandom_range(0, 65535));
      @(posedge clock);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      stim_t = 48'hFFFF_FFFF_0000;
      hold_count++;
      random_part(35);
      wait_drained();
      @(posedge clock);
      random_part(35);
      wait_drained();

      set_config($urandom_range(1, 100000), $urandom_range(1, 64), $urandom_range(1, 4096));
      @(posedge clock);
      random_part(65);
      wait_drained();

      repeat (4) @(negedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### files.f
sv/cmf_pkg.sv
sv/cmf_req_if.sv
sv/cmf_rsp_if.sv
sv/cmf_csr.sv
sv/cmf_core.sv
sv/click_motion_freeze_filter.sv
tb/tb_top.sv
